>>> rtl/core/lgd_pkg.sv
// ----------------------------------------------------------------------------
// lgd_pkg
// Shared widths and the 4x4 ordered-dither matrix of the gradient core.
// ----------------------------------------------------------------------------
package lgd_pkg;

    localparam int PX_W  = 9;
    localparam int PY_W  = 8;
    localparam int RGB_W = 16;

    // 4x4 Bayer matrix, entries 1..16
    function automatic logic [4:0] bayer4(input logic [1:0] bx, input logic [1:0] by);
        logic [4:0] v;
        case ({by, bx})
            4'h0: v = 5'd1;
            4'h1: v = 5'd9;
            4'h2: v = 5'd3;
            4'h3: v = 5'd11;
            4'h4: v = 5'd13;
            4'h5: v = 5'd5;
            4'h6: v = 5'd15;
            4'h7: v = 5'd7;
            4'h8: v = 5'd4;
            4'h9: v = 5'd12;
            4'hA: v = 5'd2;
            4'hB: v = 5'd10;
            4'hC: v = 5'd16;
            4'hD: v = 5'd8;
            4'hE: v = 5'd14;
            4'hF: v = 5'd6;
            default: v = 5'd8;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/lgd_if.sv
// ----------------------------------------------------------------------------
// lgd_in_if / lgd_out_if
// Valid/ready channels for pixel coordinates and dithered RGB565 results.
// ----------------------------------------------------------------------------
interface lgd_in_if;
    import lgd_pkg::*;
    logic            valid;
    logic            ready;
    logic [PX_W-1:0] pixel_x;
    logic [PY_W-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface lgd_out_if;
    import lgd_pkg::*;
    logic             valid;
    logic             ready;
    logic [RGB_W-1:0] pixel_rgb565;

    modport source (output valid, output pixel_rgb565, input ready);
    modport sink   (input valid, input pixel_rgb565, output ready);
endinterface

>>> rtl/core/linear_gradient_dither_rgb565_core.sv
// ----------------------------------------------------------------------------
// linear_gradient_dither_rgb565_core
// Two-color linear gradient with 4x4 ordered dither, one RGB565 pixel per
// coordinate transfer.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in carries (pixel_x, pixel_y); pix_out returns one pixel_rgb565 per
//   input transfer, in order. Both are valid/ready channels.
//   The APB port holds the endpoints and colors (register i at address 4*i).
//   Throughput: one pixel per clock while the receiver takes results and no
//   setup sequence runs. Each pixel passes three compute stages plus the
//   output register. Each register write starts a setup sequence (endpoint
//   ordering, projection products, then four 26-step serial divisions for the
//   three axis slopes and the projection reciprocal). pix_in.ready stays low
//   until it finishes. The same sequence runs after reset.
//   When the receiver stalls, each stage holds its item until the next one
//   frees up; nothing is dropped or repeated, and bubbles are filled first.
//   Reset clears the configuration registers to 0 and empties the pipeline.
// ----------------------------------------------------------------------------
module linear_gradient_dither_rgb565_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    lgd_in_if.sink      pix_in,
    lgd_out_if.source   pix_out
);
    import lgd_pkg::*;

    // register indexes
    localparam logic [2:0] R_SX = 3'd0;
    localparam logic [2:0] R_SY = 3'd1;
    localparam logic [2:0] R_EX = 3'd2;
    localparam logic [2:0] R_EY = 3'd3;
    localparam logic [2:0] R_SC = 3'd4;
    localparam logic [2:0] R_EC = 3'd5;

    // setup sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_MULC  = 3'd2;
    localparam logic [2:0] ST_KCALC = 3'd3;
    localparam logic [2:0] ST_DLOAD = 3'd4;
    localparam logic [2:0] ST_DRUN  = 3'd5;

    // gradient modes
    localparam logic [1:0] MODE_VERT = 2'd0;
    localparam logic [1:0] MODE_HORZ = 2'd1;
    localparam logic [1:0] MODE_PROJ = 2'd2;

    // pixel regions
    localparam logic [1:0] RG_LO = 2'd0;
    localparam logic [1:0] RG_HI = 2'd1;
    localparam logic [1:0] RG_AX = 2'd2;
    localparam logic [1:0] RG_PJ = 2'd3;

    localparam int DIV_W = 26;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [11:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic [23:0]        sc_reg, ec_reg;
    logic [2:0]         cfg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg <= '0;
            sy_reg <= '0;
            ex_reg <= '0;
            ey_reg <= '0;
            sc_reg <= '0;
            ec_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                R_SX:    sx_reg <= pwdata[11:0];
                R_SY:    sy_reg <= pwdata[11:0];
                R_EX:    ex_reg <= pwdata[11:0];
                R_EY:    ey_reg <= pwdata[11:0];
                R_SC:    sc_reg <= pwdata[23:0];
                R_EC:    ec_reg <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb
    begin
        case (cfg_idx)
            R_SX:    prdata = {20'd0, sx_reg};
            R_SY:    prdata = {20'd0, sy_reg};
            R_EX:    prdata = {20'd0, ex_reg};
            R_EY:    prdata = {20'd0, ey_reg};
            R_SC:    prdata = {8'd0, sc_reg};
            R_EC:    prdata = {8'd0, ec_reg};
            default: prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // derived gradient constants
    // ------------------------------------------------------------------
    logic [2:0]         st_reg;
    logic [1:0]         mode_reg;
    logic signed [11:0] p1_reg, p2_reg;
    logic signed [11:0] qx1_reg, qy1_reg, qx2_reg, qy2_reg;
    logic signed [12:0] a_reg, b_reg;
    logic [23:0]        clo_reg, chi_reg;
    logic signed [27:0] c1_reg, c2_reg;
    logic [25:0]        dc_reg;
    logic signed [37:0] k_reg [3];
    logic signed [24:0] step_reg [3];
    logic [21:0]        idc_reg;

    // serial divider
    logic [DIV_W-1:0]   dnum_reg, dden_reg, dq_reg;
    logic [DIV_W:0]     drem_reg;
    logic [4:0]         dcnt_reg;
    logic [1:0]         didx_reg;

    // PREP: mode and endpoint ordering
    logic               vert, horz, swp;
    logic [1:0]         mode_next;

    always_comb
    begin
        vert = (sx_reg == ex_reg);
        horz = (sy_reg == ey_reg);
        if (vert)
        begin
            mode_next = MODE_VERT;
            swp       = (ey_reg < sy_reg);
        end
        else if (horz)
        begin
            mode_next = MODE_HORZ;
            swp       = (ex_reg < sx_reg);
        end
        else
        begin
            mode_next = MODE_PROJ;
            swp       = (ex_reg < sx_reg);
        end
    end

    // slope numerators (end minus start color per channel, after endpoint ordering)
    logic signed [8:0]  dcol [3];
    logic [7:0]         dmag [3];
    logic signed [12:0] plen;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dcol[k] = $signed({1'b0, chi_reg[8*k +: 8]}) - $signed({1'b0, clo_reg[8*k +: 8]});
            dmag[k] = dcol[k][8] ? 8'(-dcol[k]) : dcol[k][7:0];
        end
        plen = 13'(p2_reg) - 13'(p1_reg);
    end

    // divider step
    logic [DIV_W:0]     rem_sh;
    logic               q_bit;

    always_comb
    begin
        rem_sh = {drem_reg[DIV_W-1:0], dnum_reg[DIV_W-1]};
        q_bit  = (rem_sh >= {1'b0, dden_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_PREP;
            didx_reg <= '0;
            dcnt_reg <= '0;
        end
        else if (cfg_wr)
        begin
            st_reg <= ST_PREP;
        end
        else
        begin
            case (st_reg)
                ST_PREP:  st_reg <= ST_MULC;
                ST_MULC:  st_reg <= ST_KCALC;
                ST_KCALC:
                begin
                    st_reg   <= ST_DLOAD;
                    didx_reg <= '0;
                end
                ST_DLOAD:
                begin
                    st_reg   <= ST_DRUN;
                    dcnt_reg <= '0;
                end
                ST_DRUN:
                begin
                    if (dcnt_reg == 5'(DIV_W - 1))
                    begin
                        didx_reg <= didx_reg + 2'd1;
                        st_reg   <= (didx_reg == 2'd3) ? ST_IDLE : ST_DLOAD;
                    end
                    dcnt_reg <= dcnt_reg + 5'd1;
                end
                ST_IDLE:  st_reg <= ST_IDLE;
                default:  st_reg <= ST_PREP;
            endcase
        end
    end

    // setup datapath
    always_ff @(posedge clk)
    begin
        case (st_reg)
            ST_PREP:
            begin
                mode_reg <= mode_next;
                clo_reg  <= swp ? ec_reg : sc_reg;
                chi_reg  <= swp ? sc_reg : ec_reg;
                if (mode_next == MODE_VERT)
                begin
                    p1_reg <= swp ? ey_reg : sy_reg;
                    p2_reg <= swp ? sy_reg : ey_reg;
                end
                else
                begin
                    p1_reg <= swp ? ex_reg : sx_reg;
                    p2_reg <= swp ? sx_reg : ex_reg;
                end
                qx1_reg <= swp ? ex_reg : sx_reg;
                qy1_reg <= swp ? ey_reg : sy_reg;
                qx2_reg <= swp ? sx_reg : ex_reg;
                qy2_reg <= swp ? sy_reg : ey_reg;
                a_reg   <= swp ? (13'(sx_reg) - 13'(ex_reg)) : (13'(ex_reg) - 13'(sx_reg));
                b_reg   <= swp ? (13'(sy_reg) - 13'(ey_reg)) : (13'(ey_reg) - 13'(sy_reg));
            end
            ST_MULC:
            begin
                c1_reg <= 28'(a_reg) * 28'(qx1_reg) + 28'(b_reg) * 28'(qy1_reg);
                c2_reg <= 28'(a_reg) * 28'(qx2_reg) + 28'(b_reg) * 28'(qy2_reg);
            end
            ST_KCALC:
            begin
                dc_reg <= 26'(c2_reg - c1_reg);
                for (int k = 0; k < 3; k++)
                begin
                    k_reg[k] <= 38'($signed({1'b0, clo_reg[8*k +: 8]})) * 38'(c2_reg)
                              - 38'($signed({1'b0, chi_reg[8*k +: 8]})) * 38'(c1_reg);
                end
            end
            ST_DLOAD:
            begin
                drem_reg <= '0;
                dq_reg   <= '0;
                if (didx_reg == 2'd3)
                begin
                    dnum_reg <= 26'h3FFFFF;
                    dden_reg <= dc_reg;
                end
                else
                begin
                    dnum_reg <= {2'b00, dmag[didx_reg], 16'd0};
                    dden_reg <= {14'd0, plen[11:0]};
                end
            end
            ST_DRUN:
            begin
                drem_reg <= q_bit ? (rem_sh - {1'b0, dden_reg}) : rem_sh;
                dnum_reg <= {dnum_reg[DIV_W-2:0], 1'b0};
                dq_reg   <= {dq_reg[DIV_W-2:0], q_bit};
                if (dcnt_reg == 5'(DIV_W - 1))
                begin
                    if (didx_reg == 2'd3)
                        idc_reg <= dq_reg[20:0] == 21'd0 && !q_bit && dq_reg[DIV_W-2:21] == '0
                                   ? 22'd0 : {dq_reg[20:0], q_bit};
                    else
                        step_reg[didx_reg] <= dcol[didx_reg][8]
                                              ? -25'({dq_reg[23:0], q_bit})
                                              : 25'({dq_reg[23:0], q_bit});
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // pixel pipeline
    // ------------------------------------------------------------------
    logic               v1_reg, v2_reg, v3_reg, ov_reg;
    logic               en1, en2, en3, en4;
    logic [15:0]        rgb_reg;

    assign en4 = !ov_reg || pix_out.ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign pix_in.ready      = (st_reg == ST_IDLE) && en1;
    assign pix_out.valid     = ov_reg;
    assign pix_out.pixel_rgb565 = rgb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= pix_in.valid && pix_in.ready;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) ov_reg <= v3_reg;
        end
    end

    // stage 1: projection coordinate, axis position
    logic [3:0]         bxy1_reg;
    logic signed [27:0] c_s1_reg;
    logic signed [13:0] diff1_reg;
    logic               alt1_reg, age1_reg;
    logic signed [12:0] pos;

    assign pos = (mode_reg == MODE_VERT) ? $signed({5'd0, pix_in.pixel_y})
                                         : $signed({4'd0, pix_in.pixel_x});

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            bxy1_reg  <= {pix_in.pixel_y[1:0], pix_in.pixel_x[1:0]};
            c_s1_reg  <= 28'(a_reg) * 28'($signed({1'b0, pix_in.pixel_x}))
                       + 28'(b_reg) * 28'($signed({1'b0, pix_in.pixel_y}));
            diff1_reg <= 14'(pos) - 14'(p1_reg);
            alt1_reg  <= pos < 13'(p1_reg);
            age1_reg  <= pos >= 13'(p2_reg);
        end
    end

    // stage 2: region and per-channel ramp numerators
    logic [3:0]         bxy2_reg;
    logic [1:0]         rg2_reg;
    logic [23:0]        av2_reg [3];
    logic [29:0]        pn2_reg [3];
    logic [1:0]         rg_next;

    always_comb
    begin
        if (mode_reg == MODE_PROJ)
        begin
            if (c_s1_reg < c1_reg)       rg_next = RG_LO;
            else if (c_s1_reg >= c2_reg) rg_next = RG_HI;
            else                         rg_next = RG_PJ;
        end
        else
        begin
            if (alt1_reg)      rg_next = RG_LO;
            else if (age1_reg) rg_next = RG_HI;
            else               rg_next = RG_AX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            bxy2_reg <= bxy1_reg;
            rg2_reg  <= rg_next;
            for (int k = 0; k < 3; k++)
            begin
                av2_reg[k] <= 24'($signed({9'd0, clo_reg[8*k +: 8], 16'd0})
                                  + 40'(diff1_reg) * 40'(step_reg[k]));
                pn2_reg[k] <= 30'(k_reg[k] + 38'(dcol[k]) * 38'(c_s1_reg));
            end
        end
    end

    // stage 3: reciprocal product and channel select
    logic [3:0]         bxy3_reg;
    logic               f22_reg;
    logic [29:0]        ch3_reg [3];
    logic [51:0]        prod [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            prod[k] = 52'(pn2_reg[k]) * 52'(idc_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            bxy3_reg <= bxy2_reg;
            f22_reg  <= (rg2_reg == RG_PJ);
            for (int k = 0; k < 3; k++)
            begin
                case (rg2_reg)
                    RG_LO:   ch3_reg[k] <= {6'd0, clo_reg[8*k +: 8], 16'd0};
                    RG_HI:   ch3_reg[k] <= {6'd0, chi_reg[8*k +: 8], 16'd0};
                    RG_AX:   ch3_reg[k] <= {6'd0, av2_reg[k]};
                    RG_PJ:   ch3_reg[k] <= prod[k][29:0];
                    default: ch3_reg[k] <= '0;
                endcase
            end
        end
    end

    // stage 4: dither, clamp, pack to 5:6:5
    logic signed [32:0] thr;
    logic signed [32:0] dsum [3];
    logic [5:0]         fld [3];

    always_comb
    begin
        thr = 33'($signed({1'b0, bayer4(bxy3_reg[1:0], bxy3_reg[3:2])})) - 33'sd8;
        for (int k = 0; k < 3; k++)
        begin
            if (k == 1)
                dsum[k] = $signed({3'd0, ch3_reg[k]})
                        + (f22_reg ? ((thr <<< 20) + 33'sd8388608) : ((thr <<< 14) + 33'sd131072));
            else
                dsum[k] = $signed({3'd0, ch3_reg[k]})
                        + (f22_reg ? ((thr <<< 21) + 33'sd16777216) : ((thr <<< 15) + 33'sd262144));
            if (dsum[k] < 0)
                fld[k] = '0;
            else if (f22_reg ? (dsum[k] > 33'sd1073741823) : (dsum[k] > 33'sd16777215))
                fld[k] = '1;
            else if (k == 1)
                fld[k] = f22_reg ? 6'(dsum[k] >>> 24) : 6'(dsum[k] >>> 18);
            else
                fld[k] = f22_reg ? 6'(dsum[k] >>> 25) : 6'(dsum[k] >>> 19);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
            rgb_reg <= {fld[2][4:0], fld[1], fld[0][4:0]};
    end

endmodule

>>> tb/sv/lgd_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lgd_tb_pkg
// Register map and table types shared by the gradient core testbench.
// ----------------------------------------------------------------------------
package lgd_tb_pkg;

    // register indexes, byte address is 4*index
    localparam int REG_START_X     = 0;
    localparam int REG_START_Y     = 1;
    localparam int REG_END_X       = 2;
    localparam int REG_END_Y       = 3;
    localparam int REG_START_COLOR = 4;
    localparam int REG_END_COLOR   = 5;
    localparam int REG_SPARE_LO    = 6;
    localparam int REG_SPARE_HI    = 7;

    // one gradient setting
    typedef struct packed {
        logic [11:0] sx;
        logic [11:0] sy;
        logic [11:0] ex;
        logic [11:0] ey;
        logic [23:0] sc;
        logic [23:0] ec;
    } grad_cfg_t;

    // one directed pixel, with an optional hand-worked color
    typedef struct packed {
        logic [2:0]  cfg;
        logic [8:0]  x;
        logic [7:0]  y;
        logic        chk;
        logic [15:0] rgb;
    } pixel_row_t;

endpackage

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the linear gradient / ordered dither core. A behavioral color model
// predicts each RGB565 result not hand-worked in the directed table; a
// directed table covers reset, axis ramps, projection ramps, long and
// degenerate gradients and off-screen pixels, then random settings and pixels
// run under several idle and stall mixes.
// ----------------------------------------------------------------------------
module testbench;
    import lgd_pkg::*;
    import lgd_tb_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int N_DIRECTED = 28;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lgd_in_if  pix_in ();
    lgd_out_if pix_out ();

    linear_gradient_dither_rgb565_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix_in  (pix_in),
        .pix_out (pix_out)
    );

    // model copy of the programmed setting
    logic [11:0] m_sx, m_sy, m_ex, m_ey;
    logic [23:0] m_sc, m_ec;

    logic [15:0] rgb_expected_q[$];
    int          fail_count;
    int          pixels_sent;
    int          pixels_checked;
    int          settings_used;
    int          src_idle_pct;
    int          snk_stall_pct;
    int          quiet_cycles;

    const int dither_m[16] = '{1, 9, 3, 11, 13, 5, 15, 7, 4, 12, 2, 10, 16, 8, 14, 6};

    localparam grad_cfg_t DIR_CFG[6] = '{
        '{12'd0,   12'd0,   12'd0,   12'd0,   24'h000000, 24'h000000},
        '{12'd20,  12'd10,  12'd20,  12'd200, 24'hFFFFFF, 24'h000000},
        '{12'd300, 12'd50,  12'hFF4, 12'd50,  24'h123456, 24'hFEDCBA},
        '{12'd10,  12'd20,  12'd300, 12'd220, 24'h0000FF, 24'hFF00FF},
        '{12'h800, 12'h800, 12'h7FF, 12'h7FF, 24'hFFFFFF, 24'hFFFFFF},
        '{12'd100, 12'd120, 12'd100, 12'd120, 24'hFFFFFF, 24'h00FF00}
    };

    localparam pixel_row_t DIRECTED[N_DIRECTED] = '{
        // reset: degenerate at the origin, black endpoints; only the dither offset shows
        '{3'd0, 9'd0,   8'd0,   1'b1, 16'h0000},
        '{3'd0, 9'd0,   8'd3,   1'b1, 16'h0821},
        '{3'd0, 9'd319, 8'd239, 1'b1, 16'h0000},
        '{3'd0, 9'd511, 8'd255, 1'b1, 16'h0000},
        '{3'd0, 9'd4,   8'd7,   1'b1, 16'h0821},
        // vertical ramp, white to black
        '{3'd1, 9'd0,   8'd0,   1'b1, 16'hFFFF},
        '{3'd1, 9'd319, 8'd9,   1'b1, 16'hFFFF},
        '{3'd1, 9'd5,   8'd10,  1'b0, 16'h0000},
        '{3'd1, 9'd5,   8'd100, 1'b0, 16'h0000},
        '{3'd1, 9'd5,   8'd199, 1'b0, 16'h0000},
        '{3'd1, 9'd5,   8'd200, 1'b0, 16'h0000},
        '{3'd1, 9'd1,   8'd255, 1'b1, 16'h0000},
        // horizontal ramp with the endpoints reversed
        '{3'd2, 9'd0,   8'd50,  1'b0, 16'h0000},
        '{3'd2, 9'd511, 8'd0,   1'b0, 16'h0000},
        '{3'd2, 9'd150, 8'd255, 1'b0, 16'h0000},
        '{3'd2, 9'd299, 8'd1,   1'b0, 16'h0000},
        '{3'd2, 9'd300, 8'd2,   1'b0, 16'h0000},
        // diagonal projection ramp
        '{3'd3, 9'd0,   8'd0,   1'b0, 16'h0000},
        '{3'd3, 9'd10,  8'd20,  1'b0, 16'h0000},
        '{3'd3, 9'd155, 8'd120, 1'b0, 16'h0000},
        '{3'd3, 9'd300, 8'd220, 1'b0, 16'h0000},
        '{3'd3, 9'd511, 8'd255, 1'b0, 16'h0000},
        // long gradient, reciprocal underflows to zero
        '{3'd4, 9'd0,   8'd0,   1'b0, 16'h0000},
        '{3'd4, 9'd319, 8'd239, 1'b0, 16'h0000},
        '{3'd4, 9'd100, 8'd100, 1'b0, 16'h0000},
        // degenerate point away from the origin
        '{3'd5, 9'd100, 8'd119, 1'b0, 16'h0000},
        '{3'd5, 9'd100, 8'd120, 1'b0, 16'h0000},
        '{3'd5, 9'd0,   8'd255, 1'b0, 16'h0000}
    };

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint chan8(input logic [23:0] col, input int k);
        return longint'(col[8*k +: 8]);
    endfunction

    // dither, clamp and pack three channels held at f fraction bits
    function automatic logic [15:0] dither_pack(input logic [8:0] px, input logic [7:0] py,
                                                input longint ch[3], input int f);
        longint t, hi, r, g, b;
        logic [15:0] rgb;
        t  = longint'(dither_m[{py[1:0], px[1:0]}]) - 8;
        hi = (longint'(1) << (f + 8)) - 1;
        r  = ch[0] + t * (longint'(1) << (f - 1)) + (longint'(1) << (f + 2));
        g  = ch[1] + t * (longint'(1) << (f - 2)) + (longint'(1) << (f + 1));
        b  = ch[2] + t * (longint'(1) << (f - 1)) + (longint'(1) << (f + 2));
        r  = (r < 0) ? 0 : ((r > hi) ? hi : r);
        g  = (g < 0) ? 0 : ((g > hi) ? hi : g);
        b  = (b < 0) ? 0 : ((b > hi) ? hi : b);
        rgb[4:0]   = 5'(r >> (f + 3));
        rgb[10:5]  = 6'(g >> (f + 2));
        rgb[15:11] = 5'(b >> (f + 3));
        return rgb;
    endfunction

    // gradient color of one pixel under the model setting
    function automatic logic [15:0] gradient_rgb(input logic [8:0] px, input logic [7:0] py);
        longint x1, y1, x2, y2, p, p1, p2, a, b, c1, c2, c, idc, s, e, tl;
        logic [23:0] v1, v2, tv;
        longint ch[3];
        int f;
        x1 = longint'($signed(m_sx));
        y1 = longint'($signed(m_sy));
        x2 = longint'($signed(m_ex));
        y2 = longint'($signed(m_ey));
        v1 = m_sc;
        v2 = m_ec;
        f  = 16;
        if (x1 == x2 || y1 == y2)
        begin
            if (x1 == x2)
            begin
                p = longint'(py); p1 = y1; p2 = y2;
            end
            else
            begin
                p = longint'(px); p1 = x1; p2 = x2;
            end
            if (p2 < p1)
            begin
                tl = p1; p1 = p2; p2 = tl;
                tv = v1; v1 = v2; v2 = tv;
            end
            for (int k = 0; k < 3; k++)
            begin
                s = chan8(v1, k) * 65536;
                if (p < p1)
                    ch[k] = s;
                else if (p >= p2)
                    ch[k] = chan8(v2, k) * 65536;
                else
                    ch[k] = s + (p - p1) * ((chan8(v2, k) * 65536 - s) / (p2 - p1));
            end
        end
        else
        begin
            if (x2 < x1)
            begin
                tl = x1; x1 = x2; x2 = tl;
                tl = y1; y1 = y2; y2 = tl;
                tv = v1; v1 = v2; v2 = tv;
            end
            a  = x2 - x1;
            b  = y2 - y1;
            c1 = a * x1 + b * y1;
            c2 = a * x2 + b * y2;
            c  = a * longint'(px) + b * longint'(py);
            if (c < c1 || c >= c2)
            begin
                tv = (c < c1) ? v1 : v2;
                for (int k = 0; k < 3; k++)
                    ch[k] = chan8(tv, k) * 65536;
            end
            else
            begin
                idc = longint'(32'h3FFFFF) / (c2 - c1);
                for (int k = 0; k < 3; k++)
                begin
                    s = chan8(v1, k);
                    e = chan8(v2, k);
                    ch[k] = (s * c2 - e * c1 + (e - s) * c) * idc;
                end
                f = 22;
            end
        end
        return dither_pack(px, py, ch, f);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_count++;
    endtask

    // APB write, setup then access; mirrors the register into the model
    task automatic reg_write(input int idx, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = 5'(idx * 4);
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_START_X:     m_sx = value[11:0];
            REG_START_Y:     m_sy = value[11:0];
            REG_END_X:       m_ex = value[11:0];
            REG_END_Y:       m_ey = value[11:0];
            REG_START_COLOR: m_sc = value[23:0];
            REG_END_COLOR:   m_ec = value[23:0];
            default: ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // drain the pipe, then program a full setting
    task automatic program_gradient(input grad_cfg_t cfg);
        pix_in.valid = 1'b0;
        while (rgb_expected_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        reg_write(REG_START_X, {20'($urandom), cfg.sx});
        reg_write(REG_START_Y, {20'($urandom), cfg.sy});
        reg_write(REG_END_X, {20'($urandom), cfg.ex});
        reg_write(REG_END_Y, {20'($urandom), cfg.ey});
        reg_write(REG_START_COLOR, {8'($urandom), cfg.sc});
        reg_write(REG_END_COLOR, {8'($urandom), cfg.ec});
        // writes to unmapped slots must change nothing
        reg_write(($urandom_range(1) != 0) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
        settings_used++;
    endtask

    // one coordinate transfer; entered and left at a falling edge
    task automatic send_pixel(input logic [8:0] px, input logic [7:0] py,
                              input logic chk, input logic [15:0] rgb);
        while ($urandom_range(99) < src_idle_pct)
        begin
            pix_in.valid = 1'b0;
            @(negedge clk);
        end
        pix_in.valid   = 1'b1;
        pix_in.pixel_x = px;
        pix_in.pixel_y = py;
        @(posedge clk);
        while (!pix_in.ready)
            @(posedge clk);
        rgb_expected_q.push_back(chk ? rgb : gradient_rgb(px, py));
        pixels_sent++;
        @(negedge clk);
    endtask

    function automatic logic [11:0] rand_coord();
        case ($urandom_range(7))
            0: return 12'h800;
            1: return 12'h7FF;
            2: return 12'($urandom);
            default: return 12'($signed($urandom_range(400)) - 40);
        endcase
    endfunction

    function automatic logic [23:0] rand_color();
        case ($urandom_range(5))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic grad_cfg_t rand_gradient();
        grad_cfg_t cfg;
        cfg.sx = rand_coord();
        cfg.sy = rand_coord();
        cfg.ex = rand_coord();
        cfg.ey = rand_coord();
        case ($urandom_range(5))
            0: cfg.ex = cfg.sx;
            1: cfg.ey = cfg.sy;
            2:
            begin
                cfg.ex = cfg.sx;
                cfg.ey = cfg.sy;
            end
            default: ;
        endcase
        cfg.sc = rand_color();
        cfg.ec = rand_color();
        return cfg;
    endfunction

    // receiver: ready changes on the falling edge
    always @(negedge clk)
        pix_out.ready <= ($urandom_range(99) >= snk_stall_pct);

    // result check and no-progress watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            if (pix_out.valid && pix_out.ready)
            begin
                if (rgb_expected_q.size() == 0)
                    report_mismatch($sformatf("unexpected pixel %h", pix_out.pixel_rgb565));
                else
                begin
                    if (pix_out.pixel_rgb565 !== rgb_expected_q[0])
                        report_mismatch($sformatf("pixel_rgb565 got %h want %h",
                                                  pix_out.pixel_rgb565, rgb_expected_q[0]));
                    void'(rgb_expected_q.pop_front());
                    pixels_checked++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int cur_cfg;
        int wait_cycles;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        pix_in.valid   = 1'b0;
        pix_in.pixel_x = '0;
        pix_in.pixel_y = '0;
        pix_out.ready  = 1'b0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        fail_count     = 0;
        pixels_sent    = 0;
        pixels_checked = 0;
        settings_used  = 1;
        quiet_cycles   = 0;
        m_sx = '0; m_sy = '0; m_ex = '0; m_ey = '0; m_sc = '0; m_ec = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        cur_cfg = 0;
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (int'(DIRECTED[i].cfg) != cur_cfg)
            begin
                cur_cfg = DIRECTED[i].cfg;
                program_gradient(DIR_CFG[cur_cfg]);
            end
            send_pixel(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].chk, DIRECTED[i].rgb);
        end

        // random: four idle/stall mixes, several settings in each
        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct  = (ph == 1) ? 75 : ((ph == 3) ? 31 : 0);
            snk_stall_pct = (ph == 2) ? 75 : ((ph == 3) ? 31 : 0);
            for (int s = 0; s < 8; s++)
            begin
                program_gradient(rand_gradient());
                for (int n = 0; n < 50; n++)
                begin
                    // now and then hold off until the pipe is empty
                    if ($urandom_range(99) == 0)
                    begin
                        pix_in.valid = 1'b0;
                        while (rgb_expected_q.size() != 0)
                            @(negedge clk);
                    end
                    if ($urandom_range(3) == 0)
                        send_pixel(9'($urandom), 8'($urandom), 1'b0, '0);
                    else
                        send_pixel(9'($urandom_range(319)), 8'($urandom_range(239)), 1'b0, '0);
                end
            end
        end
        pix_in.valid = 1'b0;

        // drain
        wait_cycles = 0;
        while (rgb_expected_q.size() != 0 && wait_cycles < IDLE_LIMIT)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (10) @(negedge clk);
        if (rgb_expected_q.size() != 0)
            report_mismatch($sformatf("%0d pixels never returned", rgb_expected_q.size()));

        $display("Covered %0d gradient settings (axis, diagonal, long, degenerate),",
                 settings_used);
        $display("%0d pixel transfers sent, %0d colors compared, %0d errors.",
                 pixels_sent, pixels_checked, fail_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
